FILE: hw/rtl/gyro_bias_calibrate_integrate_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gyro bias calibration and angle integration core
// Each macro expands to a clocked concurrent assertion on i_clk, disabled
// while i_rst_n is low, or to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef GYRO_BIAS_CALIBRATE_INTEGRATE_CORE_MACROS_SVH
`define GYRO_BIAS_CALIBRATE_INTEGRATE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define GBCI_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gbci assertion failed");
`define GBCI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gbci assertion failed");
`else
`define GBCI_ASSERT_SAME(lbl, ante, cons)
`define GBCI_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/gbci_pkg.sv
// ----------------------------------------------------------------------------
// gbci_pkg
// Types and constants shared by the gyro bias calibration and integration core.
// ----------------------------------------------------------------------------
package gbci_pkg;

    localparam int ANGLE_W    = 48;
    localparam int CFG_W      = 24;
    localparam int CFG_ADDR_W = 2;
    localparam int COUNT_W    = 10;
    localparam int BAND_W     = 10;
    localparam int FACTOR_W   = 24;
    localparam int FRAC_W     = 8;

    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_COUNT  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_BAND   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_FACTOR = 2'd2;

    localparam logic [COUNT_W-1:0]         COUNT_RST  = 10'd400;
    localparam logic [BAND_W-1:0]          BAND_RST   = 10'd0;
    localparam logic signed [FACTOR_W-1:0] FACTOR_RST = -24'sd51506;

    localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
    localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALIB,
        ST_DIVGO,
        ST_DIV,
        ST_RATE,
        ST_ACC,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic load_sample;
        logic cal_step;
        logic div_start;
        logic bias_load;
        logic rate_step;
        logic acc_step;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic working;
        logic cal_done;
        logic div_busy;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: hw/rtl/gbci_div.sv
// ----------------------------------------------------------------------------
// gbci_div
// Restoring divider, one quotient bit per cycle, for the bias average.
// ----------------------------------------------------------------------------
module gbci_div
    import gbci_pkg::*;
#(
    parameter int DIVD_W = 28
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIVD_W-1:0]  i_dividend,
    input  logic [COUNT_W-1:0] i_divisor,
    output logic               o_busy,
    output logic [DIVD_W-1:0]  o_quotient
);

    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic              r_busy;
    logic [STEP_W-1:0] r_steps;
    logic [DIVD_W-1:0] r_quo;
    logic [COUNT_W-1:0] r_rem;
    logic [COUNT_W-1:0] r_dvs;

    logic [COUNT_W:0]   w_trial;
    logic [COUNT_W:0]   w_diff;
    logic               w_ge;
    logic [COUNT_W-1:0] n_rem;

    assign w_trial = {r_rem, r_quo[DIVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign n_rem   = w_ge ? w_diff[COUNT_W-1:0] : w_trial[COUNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_steps <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_steps <= STEP_W'(DIVD_W);
        end else if (r_busy) begin
            r_steps <= r_steps - STEP_W'(1);
            if (r_steps == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVD_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

FILE: hw/rtl/gbci_dp.sv
// ----------------------------------------------------------------------------
// gbci_dp
// Datapath: configuration registers, calibration sum and count, bias,
// rate multiply, saturating angle accumulator and the output register.
// ----------------------------------------------------------------------------
`include "gyro_bias_calibrate_integrate_core_macros.svh"

module gbci_dp
    import gbci_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic                  i_m_tready,
    output logic                  o_out_valid,
    output logic [ANGLE_W-1:0]    o_angle,
    output logic                  o_ready_res
);

    localparam int SUM_W  = SAMPLE_BITS + COUNT_W;
    localparam int Q_W    = SUM_W + FRAC_W;
    localparam int RATE_W = Q_W + 1;
    localparam int PROD_W = RATE_W + FACTOR_W;
    localparam int ACC_W  = ((PROD_W > ANGLE_W) ? PROD_W : ANGLE_W) + 1;

    logic [COUNT_W-1:0]         r_count_cfg;
    logic [BAND_W-1:0]          r_band;
    logic signed [FACTOR_W-1:0] r_factor;

    logic                       r_working;
    logic [COUNT_W-1:0]         r_calib_cnt;
    logic [SUM_W-1:0]           r_sum;
    logic [Q_W-1:0]             r_bias;
    logic signed [ANGLE_W-1:0]  r_angle;
    logic [SAMPLE_BITS-1:0]     r_sample;
    logic signed [PROD_W-1:0]   r_prod;
    logic                       r_skip;
    logic                       r_out_valid;
    logic [ANGLE_W-1:0]         r_out_angle;
    logic                       r_out_ready;

    logic [COUNT_W-1:0]         w_need;
    logic [COUNT_W-1:0]         n_calib_cnt;
    logic signed [RATE_W-1:0]   w_rate;
    logic signed [RATE_W-1:0]   w_band;
    logic                       w_skip;
    logic signed [ACC_W-1:0]    w_acc_sum;
    logic signed [ANGLE_W-1:0]  n_angle;
    logic                       w_div_busy;
    logic [Q_W-1:0]             w_quotient;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_cfg <= COUNT_RST;
            r_band      <= BAND_RST;
            r_factor    <= FACTOR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_IDX_COUNT:  r_count_cfg <= i_cfg_wdata[COUNT_W-1:0];
                CFG_IDX_BAND:   r_band      <= i_cfg_wdata[BAND_W-1:0];
                CFG_IDX_FACTOR: r_factor    <= $signed(i_cfg_wdata[FACTOR_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    assign w_need      = (r_count_cfg == '0) ? COUNT_W'(1) : r_count_cfg;
    assign n_calib_cnt = r_calib_cnt + COUNT_W'(1);

    gbci_div #(
        .DIVD_W (Q_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({r_sum, {FRAC_W{1'b0}}}),
        .i_divisor  (w_need),
        .o_busy     (w_div_busy),
        .o_quotient (w_quotient)
    );

    assign w_rate = $signed(RATE_W'({r_sample, {FRAC_W{1'b0}}})) - $signed(RATE_W'(r_bias));
    assign w_band = $signed(RATE_W'({r_band, {FRAC_W{1'b0}}}));
    assign w_skip = (w_rate > -w_band) && (w_rate <= w_band);

    assign w_acc_sum = ACC_W'(r_angle) + ACC_W'(r_prod);

    always_comb begin
        if (w_acc_sum > ACC_W'(ANGLE_MAX)) begin
            n_angle = ANGLE_MAX;
        end else if (w_acc_sum < ACC_W'(ANGLE_MIN)) begin
            n_angle = ANGLE_MIN;
        end else begin
            n_angle = w_acc_sum[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_working   <= 1'b0;
            r_calib_cnt <= '0;
            r_sum       <= '0;
            r_bias      <= '0;
            r_angle     <= '0;
        end else begin
            if (i_cmd.cal_step) begin
                r_calib_cnt <= n_calib_cnt;
                r_sum       <= r_sum + SUM_W'(r_sample);
            end
            if (i_cmd.bias_load) begin
                r_bias    <= w_quotient;
                r_working <= 1'b1;
            end
            if (i_cmd.acc_step && !r_skip) begin
                r_angle <= n_angle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sample) begin
            r_sample <= i_sample;
        end
        if (i_cmd.rate_step) begin
            r_prod <= w_rate * r_factor;
            r_skip <= w_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_angle <= r_angle;
            r_out_ready <= r_working;
        end
    end

    assign o_stat.working  = r_working;
    assign o_stat.cal_done = (n_calib_cnt >= w_need);
    assign o_stat.div_busy = w_div_busy;
    assign o_stat.out_free = !r_out_valid || i_m_tready;

    assign o_out_valid = r_out_valid;
    assign o_angle     = r_out_angle;
    assign o_ready_res = r_out_ready;

    `GBCI_ASSERT_NEXT(a_working_sticks, r_working, r_working)
    `GBCI_ASSERT_SAME(a_working_from_bias, $rose(r_working), $past(i_cmd.bias_load))

endmodule

FILE: hw/rtl/gbci_ctrl.sv
// ----------------------------------------------------------------------------
// gbci_ctrl
// Controller state machine: sequences calibration, bias division,
// rate integration and the hand-off to the output register.
// ----------------------------------------------------------------------------
`include "gyro_bias_calibrate_integrate_core_macros.svh"

module gbci_ctrl
    import gbci_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = i_stat.working ? ST_RATE : ST_CALIB;
                end
            end
            ST_CALIB: begin
                n_state = i_stat.cal_done ? ST_DIVGO : ST_PUSH;
            end
            ST_DIVGO: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = ST_PUSH;
                end
            end
            ST_RATE: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                n_state = ST_PUSH;
            end
            ST_PUSH: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready        = 1'b1;
                o_cmd.load_sample = i_s_tvalid;
            end
            ST_CALIB: begin
                o_cmd.cal_step = 1'b1;
            end
            ST_DIVGO: begin
                o_cmd.div_start = 1'b1;
            end
            ST_DIV: begin
                o_cmd.bias_load = !i_stat.div_busy;
            end
            ST_RATE: begin
                o_cmd.rate_step = 1'b1;
            end
            ST_ACC: begin
                o_cmd.acc_step = 1'b1;
            end
            ST_PUSH: begin
                o_cmd.push = i_stat.out_free;
            end
            default: begin
            end
        endcase
    end

    `GBCI_ASSERT_NEXT(a_accept_dispatch, i_s_tvalid && o_s_tready,
                      r_state == ST_CALIB || r_state == ST_RATE)
    `GBCI_ASSERT_SAME(a_calib_not_working, r_state == ST_CALIB, !i_stat.working)
    `GBCI_ASSERT_NEXT(a_div_sets_working, r_state == ST_DIV && !i_stat.div_busy,
                      i_stat.working && r_state == ST_PUSH)

endmodule

FILE: hw/rtl/gyro_bias_calibrate_integrate_core.sv
// ----------------------------------------------------------------------------
// gyro_bias_calibrate_integrate_core
// Gyro bias calibration followed by deadband-filtered angle integration.
// ----------------------------------------------------------------------------
// Usage: raw gyro samples enter on the slave stream, one sample per
// transaction; every sample yields exactly one transaction on the master
// stream carrying the Q16.32 angle (tdata) and the ready flag (tuser).
// The first bias_sample_count samples only build the bias; the sample that
// completes it starts a restoring divider that produces one quotient bit per
// cycle, and that item is output once the division has finished.
// Other calibration samples pass from the sum update to the output register;
// working samples go through one multiply stage and one saturating
// accumulate stage before they reach it.
// One item is processed at a time; a new sample is accepted while the
// previous result still waits in the output register, and the block holds
// the finished item only if that register has not been emptied yet.
// Reset restores the register defaults, clears the angle and the bias and
// restarts calibration. Configuration writes take effect at the next clock.
// ----------------------------------------------------------------------------
module gyro_bias_calibrate_integrate_core
    import gbci_pkg::*;
#(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // Fields from bit 0: raw_sample.
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] i_s_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // Fields from bit 0: angle.
    output logic [ANGLE_W-1:0]                    o_m_tdata,
    // Fields from bit 0: ready_res.
    output logic                                  o_m_tuser,
    input  logic                                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]                 i_cfg_addr,
    input  logic [CFG_W-1:0]                      i_cfg_wdata
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    gbci_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    gbci_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_sample    (i_s_tdata[SAMPLE_BITS-1:0]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_m_tready  (i_m_tready),
        .o_out_valid (o_m_tvalid),
        .o_angle     (o_m_tdata),
        .o_ready_res (o_m_tuser)
    );

endmodule

FILE: bench/tb_gyro_bias_calibrate_integrate_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gyro_bias_calibrate_integrate_core
// Self-checking bench for the gyro bias calibration and angle integration
// core. Raw samples are streamed in with random gaps and the angle stream is
// drained with random stalls. A cycle-free model of the calibration, deadband
// and saturating integration predicts every result. The run starts with a
// directed calibration and deadband sequence. Random runs follow that drive
// the angle into both saturation limits and probe the deadband edges.
// ----------------------------------------------------------------------------
module tb_gyro_bias_calibrate_integrate_core;
    import gbci_pkg::*;

    localparam int SAMPLE_BITS = 10;
    localparam int S_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int SAMPLE_TOP  = (1 << SAMPLE_BITS) - 1;
    localparam int RUN_COUNT   = 7;

    localparam logic [CFG_ADDR_W-1:0]      CFG_IDX_NONE  = 2'd3;
    localparam logic signed [FACTOR_W-1:0] FACTOR_TOP    = 24'sh7FFFFF;
    localparam logic signed [FACTOR_W-1:0] FACTOR_BOTTOM = 24'sh800000;

    typedef enum int {
        RUN_SPREAD,
        RUN_BAND_EDGE,
        RUN_CLIMB,
        RUN_DIVE
    } t_run_kind;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        logic                      ready;
    } t_angle_result;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [ANGLE_W-1:0]    o_m_tdata;
    logic                  o_m_tuser;

    logic [SAMPLE_BITS-1:0] samples_to_send[$];
    t_angle_result          angle_results_due[$];

    logic                      cal_done   = 1'b0;
    logic [COUNT_W-1:0]        cal_cnt    = '0;
    int unsigned               cal_sum    = 0;
    int unsigned               bias_q8    = 0;
    logic signed [ANGLE_W-1:0] angle_acc  = '0;
    logic [COUNT_W-1:0]        reg_count  = COUNT_RST;
    logic [BAND_W-1:0]         reg_band   = BAND_RST;
    logic signed [FACTOR_W-1:0] reg_factor = FACTOR_RST;

    logic quiet      = 1'b0;
    int   send_gap   = 0;
    int   send_run   = 0;
    int   rcv_gap    = 0;
    int   rcv_run    = 0;
    int   mismatches = 0;

    gyro_bias_calibrate_integrate_core #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_wdata(cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_angle_result integrate_sample(input logic [SAMPLE_BITS-1:0] raw);
        int unsigned   need;
        longint        raw_q8;
        longint        bias_l;
        longint        rate;
        longint        band;
        longint        sum;
        t_angle_result res;
        if (!cal_done) begin
            need    = (reg_count == 0) ? 1 : reg_count;
            cal_sum = cal_sum + raw;
            cal_cnt = cal_cnt + 1'b1;
            if (cal_cnt >= need) begin
                bias_q8  = (cal_sum << FRAC_W) / need;
                cal_done = 1'b1;
            end
        end else begin
            raw_q8 = raw;
            raw_q8 = raw_q8 << FRAC_W;
            bias_l = bias_q8;
            rate   = raw_q8 - bias_l;
            band   = reg_band;
            band   = band << FRAC_W;
            if (!(rate > -band && rate <= band)) begin
                sum = angle_acc + rate * longint'(reg_factor);
                if (sum > longint'(ANGLE_MAX)) begin
                    sum = ANGLE_MAX;
                end else if (sum < longint'(ANGLE_MIN)) begin
                    sum = ANGLE_MIN;
                end
                angle_acc = sum[ANGLE_W-1:0];
            end
        end
        res.angle = angle_acc;
        res.ready = cal_done;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_IDX_COUNT:  reg_count  = val[COUNT_W-1:0];
            CFG_IDX_BAND:   reg_band   = val[BAND_W-1:0];
            CFG_IDX_FACTOR: reg_factor = val[FACTOR_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do begin
            @(negedge i_clk);
        end while (samples_to_send.size() != 0 || s_tvalid || angle_results_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Sender: a transaction stays offered until accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                angle_results_due.push_back(integrate_sample(s_tdata[SAMPLE_BITS-1:0]));
            end
            if (!s_tvalid || o_s_tready) begin
                if (send_gap != 0 && !quiet) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (samples_to_send.size() != 0) begin
                    send_gap = 0;
                    s_tdata  <= S_TDATA_W'(samples_to_send.pop_front());
                    s_tvalid <= 1'b1;
                    if (send_run != 0) begin
                        send_run--;
                    end else if (quiet || $urandom_range(0, 1) == 1) begin
                        send_run = $urandom_range(0, 30);
                    end else begin
                        send_gap = $urandom_range(1, 17);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        t_angle_result due;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (angle_results_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result angle=%h ready=%b",
                                              o_m_tdata, o_m_tuser));
                end else begin
                    due = angle_results_due.pop_front();
                    if (o_m_tdata !== due.angle) begin
                        report_mismatch($sformatf("angle %h, expected %h",
                                                  o_m_tdata, due.angle));
                    end
                    if (o_m_tuser !== due.ready) begin
                        report_mismatch($sformatf("ready flag %b, expected %b",
                                                  o_m_tuser, due.ready));
                    end
                end
            end
            if (rcv_gap != 0 && !quiet) begin
                rcv_gap--;
                m_tready <= 1'b0;
            end else begin
                rcv_gap = 0;
                m_tready <= 1'b1;
                if (rcv_run != 0) begin
                    rcv_run--;
                end else if (quiet || $urandom_range(0, 1) == 1) begin
                    rcv_run = $urandom_range(0, 30);
                end else begin
                    rcv_gap = $urandom_range(1, 17);
                end
            end
        end
    end

    initial begin
        t_run_kind schedule [RUN_COUNT];
        int        run_len [RUN_COUNT];
        int        s_first;
        int        s_last;
        int        bias_int;
        int        band_i;
        int        pick;
        int        p;
        int        n;
        schedule = '{RUN_CLIMB, RUN_SPREAD, RUN_BAND_EDGE, RUN_DIVE,
                     RUN_SPREAD, RUN_BAND_EDGE, RUN_SPREAD};
        run_len  = '{150, 20, 25, 285, 20, 25, 20};

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Calibration: the count is lowered to zero after two samples, so the
        // third sample completes it with the bias equal to the plain sum.
        write_reg(CFG_IDX_COUNT, CFG_W'(SAMPLE_TOP));
        s_first = $urandom_range(0, 15);
        samples_to_send.push_back('0);
        samples_to_send.push_back(SAMPLE_BITS'(s_first));
        wait_idle();
        write_reg(CFG_IDX_COUNT, '0);
        s_last = $urandom_range(500, 524) - s_first;
        bias_int = s_first + s_last;
        samples_to_send.push_back(SAMPLE_BITS'(s_last));

        samples_to_send.push_back('0);
        samples_to_send.push_back(SAMPLE_BITS'(SAMPLE_TOP));
        samples_to_send.push_back(SAMPLE_BITS'(bias_int));
        samples_to_send.push_back(SAMPLE_BITS'(bias_int + 1));
        samples_to_send.push_back(SAMPLE_BITS'(bias_int - 1));
        samples_to_send.push_back(10'h2AA);
        samples_to_send.push_back(10'h155);
        wait_idle();

        // Deadband edges: +band is ignored, -band is not.
        write_reg(CFG_IDX_BAND, 24'd3);
        write_reg(CFG_IDX_FACTOR, FACTOR_TOP);
        write_reg(CFG_IDX_NONE, CFG_W'($urandom()));
        samples_to_send.push_back(SAMPLE_BITS'(bias_int + 3));
        samples_to_send.push_back(SAMPLE_BITS'(bias_int - 3));
        samples_to_send.push_back(SAMPLE_BITS'(bias_int + 4));
        samples_to_send.push_back(SAMPLE_BITS'(bias_int - 2));
        samples_to_send.push_back(SAMPLE_BITS'(bias_int + 2));
        samples_to_send.push_back(SAMPLE_BITS'(bias_int));
        wait_idle();

        write_reg(CFG_IDX_BAND, CFG_W'(SAMPLE_TOP));
        write_reg(CFG_IDX_FACTOR, FACTOR_BOTTOM);
        write_reg(CFG_IDX_COUNT, 24'd5);
        samples_to_send.push_back('0);
        samples_to_send.push_back(SAMPLE_BITS'(SAMPLE_TOP));

        for (p = 0; p < RUN_COUNT; p++) begin
            wait_idle();
            if (p == RUN_COUNT - 1) begin
                quiet = 1'b1;
            end
            case (schedule[p])
                RUN_CLIMB: begin
                    write_reg(CFG_IDX_BAND, CFG_W'($urandom_range(0, 400)));
                    write_reg(CFG_IDX_FACTOR, FACTOR_TOP);
                end
                RUN_DIVE: begin
                    write_reg(CFG_IDX_BAND, CFG_W'($urandom_range(0, 400)));
                    write_reg(CFG_IDX_FACTOR, FACTOR_BOTTOM);
                end
                RUN_BAND_EDGE: begin
                    write_reg(CFG_IDX_BAND, CFG_W'($urandom_range(0, 40)));
                    write_reg(CFG_IDX_FACTOR, CFG_W'($urandom()));
                end
                default: begin
                    pick = $urandom_range(0, 2);
                    if (pick == 0) begin
                        write_reg(CFG_IDX_BAND, '0);
                    end else if (pick == 1) begin
                        write_reg(CFG_IDX_BAND, CFG_W'($urandom_range(0, 8)));
                    end else begin
                        write_reg(CFG_IDX_BAND, CFG_W'($urandom_range(0, SAMPLE_TOP)));
                    end
                    if ($urandom_range(0, 1) == 1) begin
                        write_reg(CFG_IDX_FACTOR, CFG_W'($urandom()));
                    end
                end
            endcase
            if ($urandom_range(0, 1) == 1) begin
                write_reg(CFG_IDX_COUNT, CFG_W'($urandom_range(0, SAMPLE_TOP)));
            end
            if ($urandom_range(0, 3) == 0) begin
                write_reg(CFG_IDX_NONE, CFG_W'($urandom()));
            end
            for (n = 0; n < run_len[p]; n++) begin
                case (schedule[p])
                    RUN_CLIMB, RUN_DIVE: begin
                        samples_to_send.push_back(
                            SAMPLE_BITS'($urandom_range(SAMPLE_TOP - 23, SAMPLE_TOP)));
                    end
                    RUN_BAND_EDGE: begin
                        band_i = reg_band;
                        pick   = $urandom_range(0, 2 * band_i + 6);
                        pick   = bias_int + pick - band_i - 3;
                        if (pick < 0) begin
                            pick = 0;
                        end else if (pick > SAMPLE_TOP) begin
                            pick = SAMPLE_TOP;
                        end
                        samples_to_send.push_back(SAMPLE_BITS'(pick));
                    end
                    default: begin
                        samples_to_send.push_back(
                            SAMPLE_BITS'($urandom_range(0, SAMPLE_TOP)));
                    end
                endcase
            end
        end

        wait_idle();
        repeat (SAMPLE_BITS + 22) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", angle_results_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: gyro_bias_calibrate_integrate_core.f
+incdir+hw/rtl
hw/rtl/gbci_pkg.sv
hw/rtl/gbci_div.sv
hw/rtl/gbci_dp.sv
hw/rtl/gbci_ctrl.sv
hw/rtl/gyro_bias_calibrate_integrate_core.sv
bench/tb_gyro_bias_calibrate_integrate_core.sv
